>>> design/dd_odo_pkg.sv
package dd_odo_pkg;

  // Field widths
  localparam int PosW   = 32;
  localparam int QuatW  = 16;
  localparam int TimeW  = 24;
  localparam int TrackW = 31;

  // Configuration space
  localparam int CfgAddrW = 3;
  localparam logic RegTrackWidth = 1'b0;
  localparam logic [TrackW-1:0] TrackReset = 31'd11469;

  // Arithmetic constants
  localparam int CordSteps = 30;
  localparam int DivSteps  = 53;
  localparam logic signed [31:0] GainQ30  = 32'sd652032874;
  localparam logic signed [31:0] RadToBam = 32'sd683565276;
  localparam logic signed [31:0] UsPerS   = 32'sd1000000;

  // Arctangent of 2^-i as a binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2E;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000028;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000002;
      5'd29:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> design/dd_odo_in_if.sv
interface dd_odo_in_if
  import dd_odo_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [PosW-1:0]  left_pos;
  logic signed [PosW-1:0]  right_pos;
  logic [TimeW-1:0]        elapsed_us;
  logic signed [QuatW-1:0] quat_x;
  logic signed [QuatW-1:0] quat_y;
  logic signed [QuatW-1:0] quat_z;
  logic signed [QuatW-1:0] quat_w;

  modport source (output valid, action, left_pos, right_pos, elapsed_us,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, action, left_pos, right_pos, elapsed_us,
                quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

>>> design/dd_odo_out_if.sv
interface dd_odo_out_if
  import dd_odo_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] heading;
  logic signed [PosW-1:0] lin_vel;
  logic signed [PosW-1:0] ang_vel;
  logic                   moving;
  logic                   initialized;

  modport source (output valid, pos_x, pos_y, heading, lin_vel, ang_vel,
                  moving, initialized, input ready);
  modport sink (input valid, pos_x, pos_y, heading, lin_vel, ang_vel,
                moving, initialized, output ready);
endinterface

>>> design/diff_drive_odometry_unit.sv
// Channel   | Dir | Handshake     | Payload
// in_ch     | in  | valid/ready   | action, wheel travel, elapsed_us, quaternion
// out_ch    | out | valid/ready   | pose, heading, velocities, flags
// cfg_*     | in  | APB write/read| track_width at byte address 0
//
// A wheel item runs three 53-step restoring divisions (rad, linear and angular
// speed) and a 30-step CORDIC rotation, which share one state sequencer and
// one 32x32 multiplier. An IMU item runs four products and 30-step CORDIC
// vectoring. First-sample and zero-time wheel items go straight to the output
// state. in_ch.ready is high only while idle. Reset (rst_n low, synchronous)
// clears control and architectural state, not datapath registers; track_width
// returns to 0.175 m. A finished result waits in the output register while the
// next item is accepted; the sequencer holds its last step if out_ch stalls.
module diff_drive_odometry_unit
  import dd_odo_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  dd_odo_in_if.sink           in_ch,
  dd_odo_out_if.source        out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_QMUL = 20'h00002,
    S_APRE = 20'h00004,
    S_ATAN = 20'h00008,
    S_PREP = 20'h00010,
    S_DIVR = 20'h00020,
    S_MULL = 20'h00040,
    S_LDL  = 20'h00080,
    S_DIVL = 20'h00100,
    S_MULT = 20'h00200,
    S_LDT  = 20'h00400,
    S_DIVT = 20'h00800,
    S_MULH = 20'h01000,
    S_MID  = 20'h02000,
    S_ROT  = 20'h04000,
    S_MULX = 20'h08000,
    S_ACCX = 20'h10000,
    S_MULY = 20'h20000,
    S_ACCY = 20'h40000,
    S_OUT  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] cnt_r;

  // Architectural state
  logic [TrackW-1:0] tw_r;
  logic              started_r;
  logic [31:0]       loff_r, roff_r, lprev_r, rprev_r;
  logic signed [31:0] x_acc_r, y_acc_r, lin_r, turn_r;
  logic [31:0]       odo_r, imu_r, used_r;

  // Item and working registers
  logic [TimeW-1:0]        dt_r;
  logic signed [QuatW-1:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0]      dl_r, dr_r, avg_r, rad_r;
  logic [31:0]             dth_r;
  logic signed [63:0]      prod_r;
  logic signed [33:0]      acc_s_r, acc_c_r;
  logic signed [37:0]      cx_r, cy_r;
  logic signed [33:0]      cz_r;
  logic                    flip_r;
  logic [52:0]             dnum_r;
  logic [31:0]             drem_r;
  logic [TrackW-1:0]       dden_r;
  logic                    dneg_r;

  // Output register
  logic              ov_r;
  logic signed [31:0] o_x_r, o_y_r, o_h_r, o_lin_r, o_ang_r;
  logic              o_mov_r, o_init_r;

  // Saturate a sign-magnitude quotient to 32 bits
  function automatic logic signed [31:0] sat_q(input logic [52:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (m > 53'h80000000) r = 32'sh80000000;
      else r = 32'(-m);
    end else begin
      if (m > 53'h7FFFFFFF) r = 32'sh7FFFFFFF;
      else r = 32'(m);
    end
    return r;
  endfunction

  // Saturating accumulate of a position
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [33:0] b);
    logic signed [34:0] s;
    logic signed [31:0] r;
    s = 35'(a) + 35'(b);
    if (s > 35'sh07FFFFFFF) r = 32'sh7FFFFFFF;
    else if (s < -35'sh080000000) r = 32'sh80000000;
    else r = s[31:0];
    return r;
  endfunction

  // Wheel deltas straight from the input
  logic [31:0]        nl, nr;
  logic signed [31:0] dl_in, dr_in;
  assign nl    = in_ch.left_pos - loff_r;
  assign nr    = in_ch.right_pos - roff_r;
  assign dl_in = nl - lprev_r;
  assign dr_in = nr - rprev_r;

  logic signed [32:0] sum33, diff33;
  assign sum33  = 33'(dl_r) + 33'(dr_r);
  assign diff33 = 33'(dr_r) - 33'(dl_r);

  // Divider load value and step
  logic signed [63:0] ld_val, ld_mag;
  logic [31:0]        dsh;
  logic               dge;
  logic [31:0]        drem_n;
  logic [52:0]        dnum_n;
  assign ld_val = (state_r == S_PREP) ? {{15{diff33[32]}}, diff33, 16'b0} : prod_r;
  assign ld_mag = ld_val[63] ? -ld_val : ld_val;
  assign dsh    = {drem_r[30:0], dnum_r[52]};
  assign dge    = dsh >= {1'b0, dden_r};
  assign drem_n = dge ? dsh - {1'b0, dden_r} : dsh;
  assign dnum_n = {dnum_r[51:0], dge};

  // CORDIC step, shared by rotation and vectoring
  logic signed [37:0] xs, ys, cx_n, cy_n;
  logic signed [33:0] at, cz_n;
  logic               up;
  assign xs   = cx_r >>> cnt_r;
  assign ys   = cy_r >>> cnt_r;
  assign at   = {2'b00, atan_lut(cnt_r[4:0])};
  assign up   = (state_r == S_ATAN) ? cy_r[37] : !cz_r[33];
  assign cx_n = up ? cx_r - ys : cx_r + ys;
  assign cy_n = up ? cy_r + xs : cy_r - xs;
  assign cz_n = up ? cz_r - at : cz_r + at;

  logic signed [37:0] cos_v, sin_v;
  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;

  // Shared multiplier operands
  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = avg_r;
    mul_b = UsPerS;
    case (state_r)
      S_QMUL: begin
        case (cnt_r[1:0])
          2'd0:    begin mul_a = 32'(qw_r); mul_b = 32'(qz_r); end
          2'd1:    begin mul_a = 32'(qx_r); mul_b = 32'(qy_r); end
          2'd2:    begin mul_a = 32'(qy_r); mul_b = 32'(qy_r); end
          default: begin mul_a = 32'(qz_r); mul_b = 32'(qz_r); end
        endcase
      end
      S_MULT:  begin mul_a = rad_r; mul_b = UsPerS; end
      S_MULH:  begin mul_a = rad_r; mul_b = RadToBam; end
      S_MULX:  begin mul_a = avg_r; mul_b = cos_v[31:0]; end
      S_MULY:  begin mul_a = avg_r; mul_b = sin_v[31:0]; end
      default: begin mul_a = avg_r; mul_b = UsPerS; end
    endcase
  end

  // Midpoint angle and quadrant fold
  logic [31:0] dth_w, mid, mid_q;
  assign dth_w = prod_r[47:16];
  assign mid   = used_r + {dth_w[31], dth_w[31:1]};
  assign mid_q = mid + 32'h40000000;

  // Yaw vector
  logic signed [37:0] s_v, c_v;
  assign s_v = 38'(acc_s_r) <<< 1;
  assign c_v = 38'sd268435456 - (38'(acc_c_r) <<< 1);

  logic out_free, in_fire;
  assign out_free = !ov_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.action) state_nxt = S_QMUL;
          else if (!started_r || in_ch.elapsed_us == '0) state_nxt = S_OUT;
          else state_nxt = S_PREP;
        end
      end
      S_QMUL: if (cnt_r == 6'd4) state_nxt = S_APRE;
      S_APRE: state_nxt = (s_v == '0) ? S_OUT : S_ATAN;
      S_ATAN: if (cnt_r == 6'(CordSteps - 1)) state_nxt = S_OUT;
      S_PREP: state_nxt = S_DIVR;
      S_DIVR: if (cnt_r == 6'(DivSteps - 1)) state_nxt = S_MULL;
      S_MULL: state_nxt = S_LDL;
      S_LDL:  state_nxt = S_DIVL;
      S_DIVL: if (cnt_r == 6'(DivSteps - 1)) state_nxt = S_MULT;
      S_MULT: state_nxt = S_LDT;
      S_LDT:  state_nxt = S_DIVT;
      S_DIVT: if (cnt_r == 6'(DivSteps - 1)) state_nxt = S_MULH;
      S_MULH: state_nxt = S_MID;
      S_MID:  state_nxt = S_ROT;
      S_ROT:  if (cnt_r == 6'(CordSteps - 1)) state_nxt = S_MULX;
      S_MULX: state_nxt = S_ACCX;
      S_ACCX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_ACCY;
      S_ACCY: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      tw_r      <= TrackReset;
      started_r <= 1'b0;
      loff_r    <= '0;
      roff_r    <= '0;
      lprev_r   <= '0;
      rprev_r   <= '0;
      x_acc_r   <= '0;
      y_acc_r   <= '0;
      odo_r     <= '0;
      imu_r     <= '0;
      used_r    <= '0;
      lin_r     <= '0;
      turn_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;

      // Register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == RegTrackWidth)
        tw_r <= cfg_pwdata[TrackW-1:0];

      case (state_r)
        S_IDLE: begin
          if (in_fire && !in_ch.action) begin
            if (!started_r) begin
              loff_r    <= in_ch.left_pos;
              roff_r    <= in_ch.right_pos;
              lprev_r   <= '0;
              rprev_r   <= '0;
              lin_r     <= '0;
              turn_r    <= '0;
              started_r <= 1'b1;
            end else if (in_ch.elapsed_us == '0) begin
              lin_r  <= '0;
              turn_r <= '0;
            end else begin
              lprev_r <= nl;
              rprev_r <= nr;
            end
          end
        end
        S_APRE: if (s_v == '0) imu_r <= c_v[37] ? 32'h80000000 : 32'h0;
        S_ATAN: if (cnt_r == 6'(CordSteps - 1))
                  imu_r <= (cy_r != '0) ? cz_n[31:0] : cz_r[31:0];
        S_DIVL: if (cnt_r == 6'(DivSteps - 1)) lin_r <= sat_q(dnum_n, dneg_r);
        S_DIVT: if (cnt_r == 6'(DivSteps - 1)) turn_r <= sat_q(dnum_n, dneg_r);
        S_ACCX: x_acc_r <= sat_add(x_acc_r, prod_r[63:30]);
        S_ACCY: begin
          y_acc_r <= sat_add(y_acc_r, prod_r[63:30]);
          odo_r   <= odo_r + dth_r;
          used_r  <= (imu_r != '0) ? imu_r : odo_r + dth_r;
        end
        default: ;
      endcase

      // Output register
      if (state_r == S_OUT && out_free) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a * mul_b);
    case (state_r)
      S_IDLE: begin
        dt_r <= in_ch.elapsed_us;
        qx_r <= in_ch.quat_x;
        qy_r <= in_ch.quat_y;
        qz_r <= in_ch.quat_z;
        qw_r <= in_ch.quat_w;
        dl_r <= dl_in;
        dr_r <= dr_in;
      end
      S_QMUL: begin
        case (cnt_r[2:0])
          3'd1:    acc_s_r <= 34'(signed'(prod_r[31:0]));
          3'd2:    acc_s_r <= acc_s_r + 34'(signed'(prod_r[31:0]));
          3'd3:    acc_c_r <= 34'(signed'(prod_r[31:0]));
          3'd4:    acc_c_r <= acc_c_r + 34'(signed'(prod_r[31:0]));
          default: ;
        endcase
      end
      S_APRE: begin
        if (c_v[37]) begin
          if (!s_v[37]) begin
            cx_r <= s_v;
            cy_r <= -c_v;
            cz_r <= 34'h040000000;
          end else begin
            cx_r <= -s_v;
            cy_r <= c_v;
            cz_r <= 34'h0C0000000;
          end
        end else begin
          cx_r <= c_v;
          cy_r <= s_v;
          cz_r <= '0;
        end
      end
      S_ATAN: begin
        if (cy_r != '0) begin
          cx_r <= cx_n;
          cy_r <= cy_n;
          cz_r <= cz_n;
        end
      end
      S_PREP: begin
        avg_r  <= sum33[32:1];
        dnum_r <= ld_mag[52:0];
        dneg_r <= ld_val[63];
        drem_r <= '0;
        dden_r <= (tw_r == '0) ? TrackW'(1) : tw_r;
      end
      S_LDL, S_LDT: begin
        dnum_r <= ld_mag[52:0];
        dneg_r <= ld_val[63];
        drem_r <= '0;
        dden_r <= TrackW'(dt_r);
      end
      S_DIVR, S_DIVL, S_DIVT: begin
        dnum_r <= dnum_n;
        drem_r <= drem_n;
        if (state_r == S_DIVR && cnt_r == 6'(DivSteps - 1))
          rad_r <= sat_q(dnum_n, dneg_r);
      end
      S_MID: begin
        dth_r  <= dth_w;
        flip_r <= mid_q[31];
        cz_r   <= mid_q[31] ? 34'(signed'(mid + 32'h80000000)) : 34'(signed'(mid));
        cx_r   <= 38'(GainQ30);
        cy_r   <= '0;
      end
      S_ROT: begin
        cx_r <= cx_n;
        cy_r <= cy_n;
        cz_r <= cz_n;
      end
      S_OUT: begin
        if (out_free) begin
          o_x_r    <= x_acc_r;
          o_y_r    <= y_acc_r;
          o_h_r    <= used_r;
          o_lin_r  <= lin_r;
          o_ang_r  <= turn_r;
          o_mov_r  <= (lin_r != '0) || (turn_r != '0);
          o_init_r <= started_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pos_x       = o_x_r;
  assign out_ch.pos_y       = o_y_r;
  assign out_ch.heading     = o_h_r;
  assign out_ch.lin_vel     = o_lin_r;
  assign out_ch.ang_vel     = o_ang_r;
  assign out_ch.moving      = o_mov_r;
  assign out_ch.initialized = o_init_r;

  // Register read
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegTrackWidth) ? {1'b0, tw_r} : 32'h0;

endmodule
